// ===== src/pgr_pkg.sv =====
// ============================================================================
// pgr_pkg: shared types and constants of the PCM16 gain ramp
// Payload structs, state encodings, register indexes and arithmetic widths.
// ============================================================================
`default_nettype none

package pgr_pkg;

    // Unity gain in 1/10000 units and range limits
    localparam int unsigned GAIN_UNITY        = 10000;
    localparam int unsigned MAX_BUFFER_FRAMES = 4096;
    localparam int unsigned MAX_CHANNELS      = 8;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned GAIN_W   = 14;
    localparam int unsigned FRAMES_W = 13;
    localparam int unsigned FPOS_W   = 12;
    localparam int unsigned CPOS_W   = 3;
    localparam int unsigned CHCNT_W  = 4;

    // Serial multiply-divide unit: q = (a * b) / d
    localparam int unsigned MD_A_W   = SAMPLE_W;
    localparam int unsigned MD_B_W   = GAIN_W;
    localparam int unsigned MD_D_W   = GAIN_W;
    localparam int unsigned MD_P_W   = MD_A_W + MD_B_W;
    localparam int unsigned MD_CNT_W = $clog2(MD_P_W);

    // Configuration register indexes
    localparam logic [1:0] CFG_VOLUME_LEVEL  = 2'd0;
    localparam logic [1:0] CFG_PLAYBACK_ON   = 2'd1;
    localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic [FRAMES_W-1:0]        buffer_frames;
    } pgr_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       buffer_last;
    } pgr_out_t;

    typedef struct packed {
        logic [MD_A_W-1:0] a;
        logic [MD_B_W-1:0] b;
        logic [MD_D_W-1:0] d;
    } md_req_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } md_state_t;

    typedef enum logic [2:0] {
        PGR_IDLE,
        PGR_GAIN_GO,
        PGR_GAIN_WAIT,
        PGR_SCALE_GO,
        PGR_SCALE_WAIT,
        PGR_PUSH
    } pgr_state_t;

endpackage

`default_nettype wire

// ===== src/pgr_muldiv.sv =====
// ============================================================================
// pgr_muldiv: bit-serial unsigned multiply then divide
// Shift-add multiply, one multiplier bit per cycle, followed by a restoring
// divide, one quotient bit per cycle. Quotient low bits are presented on q.
// ============================================================================
`default_nettype none

module pgr_muldiv (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire pgr_pkg::md_req_t            req,
    output logic                             busy,
    output logic                             done,
    output logic [pgr_pkg::MD_A_W-1:0]       q
);

    localparam int unsigned PW = pgr_pkg::MD_P_W;
    localparam int unsigned AW = pgr_pkg::MD_A_W;
    localparam int unsigned BW = pgr_pkg::MD_B_W;
    localparam int unsigned DW = pgr_pkg::MD_D_W;
    localparam int unsigned CW = pgr_pkg::MD_CNT_W;

    pgr_pkg::md_state_t state_reg, state_next;
    logic [CW-1:0]      cnt_reg;
    logic [AW-1:0]      a_reg;
    logic [DW-1:0]      d_reg;
    logic [PW-1:0]      prod_reg;
    logic [DW-1:0]      rem_reg;
    logic               done_reg;

    logic [AW:0]        mul_sum;
    logic [DW:0]        trial;
    logic               q_bit;
    logic               last_step;

    assign mul_sum = {1'b0, prod_reg[PW-1:BW]} + (prod_reg[0] ? {1'b0, a_reg} : '0);
    assign trial   = {rem_reg, prod_reg[PW-1]};
    assign q_bit   = (trial >= {1'b0, d_reg});

    always_comb begin
        state_next = state_reg;
        last_step  = 1'b0;
        case (state_reg)
            pgr_pkg::MD_IDLE: begin
                if (start) begin
                    state_next = pgr_pkg::MD_MUL;
                end
            end
            pgr_pkg::MD_MUL: begin
                if (cnt_reg == CW'(BW - 1)) begin
                    state_next = pgr_pkg::MD_DIV;
                end
            end
            pgr_pkg::MD_DIV: begin
                if (cnt_reg == CW'(PW - 1)) begin
                    last_step  = 1'b1;
                    state_next = pgr_pkg::MD_IDLE;
                end
            end
            default: begin
                state_next = pgr_pkg::MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pgr_pkg::MD_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= last_step;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            pgr_pkg::MD_IDLE: begin
                if (start) begin
                    a_reg    <= req.a;
                    d_reg    <= req.d;
                    prod_reg <= {{AW{1'b0}}, req.b};
                    cnt_reg  <= '0;
                end
            end
            pgr_pkg::MD_MUL: begin
                // add into the upper half, shift the multiplier out the bottom
                prod_reg <= {mul_sum, prod_reg[BW-1:1]};
                rem_reg  <= '0;
                cnt_reg  <= (cnt_reg == CW'(BW - 1)) ? '0 : cnt_reg + 1'b1;
            end
            pgr_pkg::MD_DIV: begin
                rem_reg  <= q_bit ? DW'(trial - {1'b0, d_reg}) : trial[DW-1:0];
                prod_reg <= {prod_reg[PW-2:0], q_bit};
                cnt_reg  <= cnt_reg + 1'b1;
            end
            default: begin
                cnt_reg <= '0;
            end
        endcase
    end

    assign busy = (state_reg != pgr_pkg::MD_IDLE);
    assign done = done_reg;
    assign q    = prod_reg[AW-1:0];

endmodule

`default_nettype wire

// ===== src/pcm16_gain_ramp.sv =====
// ============================================================================
// pcm16_gain_ramp: linear per-buffer gain ramp for interleaved PCM16
// Scales each channel sample by a frame gain that ramps from the previous
// buffer's target to the current target across the buffer.
// ============================================================================
// Usage:
//   s_valid/s_ready/s_data carry one interleaved channel sample per
//   transaction together with the buffer length in frames. m_valid/m_ready/
//   m_data return one scaled sample per input transaction, flagged with
//   buffer_last on the final sample of a buffer. cfg_valid/cfg_ready with
//   cfg_index/cfg_data write volume_level, playback_on and channel_count;
//   cfg_ready is always high, writes should land while the block is idle.
// Sequencing:
//   Every multiply and divide runs through one bit-serial unit; each
//   operation takes 14 multiply steps and 30 divide steps, then a handoff.
//   A sample that is not the first channel of a frame uses it once; the
//   first channel of a frame first computes the frame gain, then scales.
//   One item is in flight at a time: the next transaction is accepted only
//   once the finished result has been pushed into the output register.
// Reset and stall:
//   aresetn (synchronous, active low) restores the default registers and
//   starts a fresh buffer with start gain at unity. A finished result sits
//   in the output register; the next input is accepted and processed while
//   it waits, and that next result holds until m_ready frees the register.
// ============================================================================
`default_nettype none

module pcm16_gain_ramp (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire pgr_pkg::pgr_in_t                   s_data,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output pgr_pkg::pgr_out_t                       m_data,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [1:0]                         cfg_index,
    input  wire logic [pgr_pkg::GAIN_W-1:0]         cfg_data
);

    localparam int unsigned GW = pgr_pkg::GAIN_W;
    localparam int unsigned SW = pgr_pkg::SAMPLE_W;
    localparam int unsigned NW = pgr_pkg::FRAMES_W;
    localparam int unsigned FW = pgr_pkg::FPOS_W;
    localparam int unsigned PW = pgr_pkg::CPOS_W;
    localparam int unsigned HW = pgr_pkg::CHCNT_W;

    // ---------------------------------------------------------------- config
    logic [GW-1:0] vol_reg;
    logic          play_reg;
    logic [HW-1:0] chcnt_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vol_reg   <= GW'(pgr_pkg::GAIN_UNITY);
            play_reg  <= 1'b1;
            chcnt_reg <= HW'(2);
        end else if (cfg_valid) begin
            case (cfg_index)
                pgr_pkg::CFG_VOLUME_LEVEL:  vol_reg   <= cfg_data;
                pgr_pkg::CFG_PLAYBACK_ON:   play_reg  <= cfg_data[0];
                pgr_pkg::CFG_CHANNEL_COUNT: chcnt_reg <= cfg_data[HW-1:0];
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    // ----------------------------------------------------------- ramp state
    pgr_pkg::pgr_state_t state_reg, state_next;

    logic [GW-1:0] base_gain_reg;
    logic [GW-1:0] goal_gain_reg;
    logic [GW-1:0] frame_gain_reg;
    logic [FW-1:0] frame_pos_reg;
    logic [PW-1:0] chan_pos_reg;

    // per-transaction operands
    logic [SW-1:0] smag_reg;
    logic          sneg_reg;
    logic          last_reg;
    logic [GW-1:0] op_start_reg;
    logic [GW-1:0] dmag_reg;
    logic          dneg_reg;
    logic [NW-1:0] step_reg;
    logic [NW-1:0] n_reg;

    pgr_pkg::pgr_out_t out_reg;
    logic              m_valid_reg;

    logic            accept;
    logic            push;
    logic            frame_start;
    logic [NW-1:0]   n_clamp;
    logic [HW-1:0]   ch_clamp;
    logic [GW-1:0]   vol_sat;
    logic [GW-1:0]   tgt_eff;
    logic [GW:0]     delta;
    logic [NW-1:0]   fpos_inc;
    logic [NW-1:0]   step;
    logic            frame_end;
    logic            buffer_end;
    logic            s_neg;

    // serial unit hookup
    pgr_pkg::md_req_t       md_req;
    logic                   md_start;
    logic                   md_busy;
    logic                   md_done;
    logic [pgr_pkg::MD_A_W-1:0] md_q;

    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == pgr_pkg::PGR_IDLE);

    // Clamp the frame count and channel count into their legal ranges
    always_comb begin
        if (s_data.buffer_frames == '0) begin
            n_clamp = NW'(1);
        end else if (s_data.buffer_frames > NW'(pgr_pkg::MAX_BUFFER_FRAMES)) begin
            n_clamp = NW'(pgr_pkg::MAX_BUFFER_FRAMES);
        end else begin
            n_clamp = s_data.buffer_frames;
        end

        if (chcnt_reg == '0) begin
            ch_clamp = HW'(1);
        end else if (chcnt_reg > HW'(pgr_pkg::MAX_CHANNELS)) begin
            ch_clamp = HW'(pgr_pkg::MAX_CHANNELS);
        end else begin
            ch_clamp = chcnt_reg;
        end
    end

    assign frame_start = (frame_pos_reg == '0) && (chan_pos_reg == '0);
    assign vol_sat     = (vol_reg > GW'(pgr_pkg::GAIN_UNITY)) ?
                         GW'(pgr_pkg::GAIN_UNITY) : vol_reg;
    // latch a fresh target at the first sample of a buffer
    assign tgt_eff     = frame_start ? (play_reg ? vol_sat : '0) : goal_gain_reg;
    assign delta       = {1'b0, tgt_eff} - {1'b0, base_gain_reg};
    assign fpos_inc    = {1'b0, frame_pos_reg} + 1'b1;
    assign step        = (fpos_inc > n_clamp) ? n_clamp : fpos_inc;
    assign frame_end   = ({{(HW-PW){1'b0}}, chan_pos_reg} + 1'b1) >= ch_clamp;
    assign buffer_end  = frame_end && (fpos_inc >= n_clamp);
    assign s_neg       = s_data.sample_in[SW-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_gain_reg  <= GW'(pgr_pkg::GAIN_UNITY);
            goal_gain_reg  <= '0;
            frame_gain_reg <= '0;
            frame_pos_reg  <= '0;
            chan_pos_reg   <= '0;
        end else begin
            if (accept) begin
                goal_gain_reg <= tgt_eff;
                if (buffer_end) begin
                    // hand the target over as the next buffer's start
                    base_gain_reg <= tgt_eff;
                    frame_pos_reg <= '0;
                    chan_pos_reg  <= '0;
                end else if (frame_end) begin
                    frame_pos_reg <= fpos_inc[FW-1:0];
                    chan_pos_reg  <= '0;
                end else begin
                    chan_pos_reg <= chan_pos_reg + 1'b1;
                end
            end
            if (state_reg == pgr_pkg::PGR_GAIN_WAIT && md_done) begin
                frame_gain_reg <= dneg_reg ? (op_start_reg - md_q[GW-1:0])
                                           : (op_start_reg + md_q[GW-1:0]);
            end
        end
    end

    // capture operands of the accepted transaction
    always_ff @(posedge aclk) begin
        if (accept) begin
            smag_reg     <= s_neg ? SW'(-s_data.sample_in) : SW'(s_data.sample_in);
            sneg_reg     <= s_neg;
            last_reg     <= buffer_end;
            op_start_reg <= base_gain_reg;
            dneg_reg     <= delta[GW];
            dmag_reg     <= delta[GW] ? GW'(-delta) : delta[GW-1:0];
            step_reg     <= step;
            n_reg        <= n_clamp;
        end
    end

    // ------------------------------------------------------------ sequencer
    always_comb begin
        state_next = state_reg;
        md_start   = 1'b0;
        push       = 1'b0;
        case (state_reg)
            pgr_pkg::PGR_IDLE: begin
                if (accept) begin
                    state_next = (chan_pos_reg == '0) ? pgr_pkg::PGR_GAIN_GO
                                                      : pgr_pkg::PGR_SCALE_GO;
                end
            end
            pgr_pkg::PGR_GAIN_GO: begin
                md_start   = 1'b1;
                state_next = pgr_pkg::PGR_GAIN_WAIT;
            end
            pgr_pkg::PGR_GAIN_WAIT: begin
                if (md_done) begin
                    state_next = pgr_pkg::PGR_SCALE_GO;
                end
            end
            pgr_pkg::PGR_SCALE_GO: begin
                md_start   = 1'b1;
                state_next = pgr_pkg::PGR_SCALE_WAIT;
            end
            pgr_pkg::PGR_SCALE_WAIT: begin
                if (md_done) begin
                    state_next = pgr_pkg::PGR_PUSH;
                end
            end
            pgr_pkg::PGR_PUSH: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    push       = 1'b1;
                    state_next = pgr_pkg::PGR_IDLE;
                end
            end
            default: begin
                state_next = pgr_pkg::PGR_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pgr_pkg::PGR_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Frame gain: |delta| * step / n. Sample: |sample| * gain / 10000.
    always_comb begin
        if (state_reg == pgr_pkg::PGR_GAIN_GO) begin
            md_req.a = {{(pgr_pkg::MD_A_W-GW){1'b0}}, dmag_reg};
            md_req.b = {{(pgr_pkg::MD_B_W-NW){1'b0}}, step_reg};
            md_req.d = {{(pgr_pkg::MD_D_W-NW){1'b0}}, n_reg};
        end else begin
            md_req.a = smag_reg;
            md_req.b = frame_gain_reg;
            md_req.d = pgr_pkg::MD_D_W'(pgr_pkg::GAIN_UNITY);
        end
    end

    pgr_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (md_start),
        .req     (md_req),
        .busy    (md_busy),
        .done    (md_done),
        .q       (md_q)
    );

    // --------------------------------------------------------- output stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            out_reg.sample_out  <= sneg_reg ? SW'(-md_q) : md_q;
            out_reg.buffer_last <= last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // ----------------------------------------------------------- assertions
    a_frame_gain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_gain_reg <= GW'(pgr_pkg::GAIN_UNITY))
        else $error("frame gain above unity");

    a_base_gain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        base_gain_reg <= GW'(pgr_pkg::GAIN_UNITY))
        else $error("start gain above unity");

    a_idle_unit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pgr_pkg::PGR_IDLE) |-> !md_busy)
        else $error("multiply-divide unit busy while idle");

    a_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        md_done |-> (state_reg == pgr_pkg::PGR_GAIN_WAIT ||
                     state_reg == pgr_pkg::PGR_SCALE_WAIT))
        else $error("unexpected multiply-divide completion");

endmodule

`default_nettype wire

// ===== tb/sv/pcm16_gain_ramp_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pcm16_gain_ramp_tb: self-checking bench for the PCM16 gain ramp
// Drives buffers of interleaved samples with random gaps and output stalls,
// predicts every scaled sample in a scoreboard and compares field by field.
// ============================================================================

module pcm16_gain_ramp_tb;

    import pgr_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 4;
    localparam int QUIET_LIMIT  = 2000;   // cycles without any transaction
    localparam int ITEM_TARGET  = 1700;
    localparam int CALM_FROM    = 1500;   // no random gaps or stalls from here on
    localparam int TAIL_CYCLES  = 200;
    localparam int REPORT_MAX   = 10;

    // Index 3 maps to no register; writes there must be ignored
    localparam logic [1:0] CFG_SPARE = 2'd3;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the ramp state and holds the scaled samples due
    // ------------------------------------------------------------------------
    class gain_ramp_board;
        int unsigned volume;
        int unsigned playback;
        int unsigned chan_count;
        longint      base_gain;
        longint      goal_gain;
        longint      frame_gain;
        int unsigned frame_pos;
        int unsigned chan_pos;
        pgr_out_t    scaled_due[$];
        int          mismatches;

        function new();
            volume      = GAIN_UNITY;
            playback    = 1;
            chan_count  = 2;
            base_gain   = GAIN_UNITY;
            goal_gain   = 0;
            frame_gain  = 0;
            frame_pos   = 0;
            chan_pos    = 0;
            mismatches  = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [GAIN_W-1:0] data);
            case (idx)
                CFG_VOLUME_LEVEL:  volume     = data;
                CFG_PLAYBACK_ON:   playback   = data[0];
                CFG_CHANNEL_COUNT: chan_count = data[CHCNT_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance the ramp by one accepted sample and queue its result
        function void take_sample(pgr_in_t item);
            longint   sample;
            longint   frames;
            longint   chans;
            longint   step;
            longint   vol;
            longint   scaled;
            bit       frame_end;
            bit       buffer_end;
            pgr_out_t res;

            sample = item.sample_in;
            frames = item.buffer_frames;
            if (frames < 1) frames = 1;
            else if (frames > MAX_BUFFER_FRAMES) frames = MAX_BUFFER_FRAMES;
            chans = chan_count;
            if (chans < 1) chans = 1;
            else if (chans > MAX_CHANNELS) chans = MAX_CHANNELS;

            // latch the target at the first sample of a buffer
            if (frame_pos == 0 && chan_pos == 0) begin
                vol = (volume > GAIN_UNITY) ? GAIN_UNITY : volume;
                goal_gain = playback ? vol : 0;
            end
            // frame gain at the first channel, clamped to the target once the
            // position runs past a shrunken frame count
            if (chan_pos == 0) begin
                step = frame_pos + 1;
                if (step > frames) step = frames;
                frame_gain = base_gain + (goal_gain - base_gain) * step / frames;
            end

            scaled = sample * frame_gain / longint'(GAIN_UNITY);

            frame_end  = (chan_pos + 1 >= chans);
            buffer_end = frame_end && (frame_pos + 1 >= frames);

            if (buffer_end) begin
                base_gain = goal_gain;
                frame_pos = 0;
                chan_pos  = 0;
            end else if (frame_end) begin
                frame_pos = frame_pos + 1;
                chan_pos  = 0;
            end else begin
                chan_pos = chan_pos + 1;
            end

            res.sample_out  = scaled[SAMPLE_W-1:0];
            res.buffer_last = buffer_end;
            scaled_due.push_back(res);
        endfunction

        function void match_output(pgr_out_t got);
            pgr_out_t want;

            if (scaled_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: sample_out %0d buffer_last %0b",
                             got.sample_out, got.buffer_last);
                return;
            end
            want = scaled_due.pop_front();
            if (got.sample_out !== want.sample_out || got.buffer_last !== want.buffer_last) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("mismatch: expected sample_out %0d buffer_last %0b, got %0d %0b",
                             want.sample_out, want.buffer_last,
                             got.sample_out, got.buffer_last);
            end
        endfunction

        function int pending();
            return scaled_due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------------
    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    pgr_in_t             s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    pgr_out_t            m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [1:0]          cfg_index = '0;
    logic [GAIN_W-1:0]   cfg_data  = '0;

    gain_ramp_board board;

    bit          calm        = 1'b0;  // set for the last part: no random input gaps or output stalls
    int          items_sent  = 0;
    int unsigned chan_now    = 2;     // effective channel count for framing
    int          gap_pct     = 0;     // chance of an input gap per transaction
    int          stall_pct   = 0;     // chance of an output stall per cycle
    int          stall_left  = 0;
    int          idle_cycles = 0;

    pcm16_gain_ramp i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Result side: hold m_ready low in random bursts of stall cycles
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < stall_pct)
                stall_left = $urandom_range(1, 4);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: every handler sees pre-edge values, so no race with the block
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
            if (s_valid && s_ready)     board.take_sample(s_data);
            if (m_valid && m_ready)     board.match_output(m_data);
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= QUIET_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------

    // Offer one sample; valid stays high across back-to-back transactions
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp,
                               input logic [FRAMES_W-1:0] frames);
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_data  <= '{sample_in: smp, buffer_frames: frames};
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (items_sent >= CALM_FROM) calm = 1'b1;
    endtask

    // Drop valid and wait until every predicted sample has come back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.pending() != 0) @(posedge aclk);
    endtask

    task automatic set_register(input logic [1:0] idx, input logic [GAIN_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        if (idx == CFG_CHANNEL_COUNT) begin
            chan_now = value[CHCNT_W-1:0];
            if (chan_now < 1) chan_now = 1;
            else if (chan_now > MAX_CHANNELS) chan_now = MAX_CHANNELS;
        end
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 11))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return '1;
            3:       return 16'sd1;
            4:       return '0;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_volume();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return GAIN_W'(GAIN_UNITY);
            2:       return '1;
            3:       return GAIN_W'($urandom_range(GAIN_UNITY + 1, (1 << GAIN_W) - 1));
            default: return GAIN_W'($urandom_range(0, GAIN_UNITY));
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_channels();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return GAIN_W'(15);
            2:       return GAIN_W'($urandom);
            default: return GAIN_W'($urandom_range(1, MAX_CHANNELS));
        endcase
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 10;
            2:       return 30;
            default: return 60;
        endcase
    endfunction

    // One well-formed buffer: frames times the current channel count
    task automatic send_buffer(input int frames);
        repeat (frames * chan_now) send_sample(pick_sample(), FRAMES_W'(frames));
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int kind;
        int big;

        board = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: unity start and unity target, sample extremes
        send_sample(16'sh7FFF, 13'd2);
        send_sample(16'sh8000, 13'd2);
        send_sample(-16'sd1, 13'd2);
        send_sample(16'sd1, 13'd2);

        // Playback off: ramp from unity down to silence over two frames
        drain();
        set_register(CFG_PLAYBACK_ON, 14'd0);
        set_register(CFG_CHANNEL_COUNT, 14'd3);
        send_sample(16'sh7FFF, 13'd2);
        send_sample(16'sh8000, 13'd2);
        send_sample(16'sd20000, 13'd2);
        send_sample(-16'sd20000, 13'd2);
        send_sample(16'sh7FFF, 13'd2);
        send_sample(-16'sd1, 13'd2);

        // Volume above unity saturates; a zero frame count acts as one
        drain();
        set_register(CFG_VOLUME_LEVEL, '1);
        set_register(CFG_PLAYBACK_ON, 14'd1);
        set_register(CFG_CHANNEL_COUNT, 14'd1);
        send_sample(16'sh8000, 13'd0);

        // Zero channels acts as one; oversize frame count clamps, then a
        // shrunken frame count ends the buffer at the target gain
        drain();
        set_register(CFG_VOLUME_LEVEL, 14'd3);
        set_register(CFG_CHANNEL_COUNT, 14'd0);
        send_sample(16'sh7FFF, '1);
        send_sample(16'sh8000, '1);
        send_sample(16'sh7FFF, 13'd1);

        // Channel count above the maximum clamps; stop mid-frame
        drain();
        set_register(CFG_CHANNEL_COUNT, 14'd15);
        send_sample(16'sh7FFF, 13'd2);
        send_sample(16'sh8000, 13'd2);
        send_sample(16'sd12345, 13'd2);

        // Shrink the channel count mid-frame and change the volume mid-buffer;
        // the new volume waits for the next buffer, the spare index does nothing
        drain();
        set_register(CFG_VOLUME_LEVEL, 14'd5000);
        set_register(CFG_CHANNEL_COUNT, 14'd2);
        set_register(CFG_SPARE, '1);
        send_sample(-16'sd12345, 13'd2);
        send_sample(16'sh7FFF, 13'd2);
        send_sample(16'sh8000, 13'd2);
        send_sample(16'sh7FFF, 13'd1);
        send_sample(16'sh8000, 13'd1);

        // Random phases: new settings between phases, mostly whole buffers
        while (items_sent < ITEM_TARGET) begin
            drain();
            if ($urandom_range(0, 2) != 0) set_register(CFG_VOLUME_LEVEL, pick_volume());
            if ($urandom_range(0, 2) != 0) set_register(CFG_PLAYBACK_ON, GAIN_W'($urandom));
            if ($urandom_range(0, 2) != 0) set_register(CFG_CHANNEL_COUNT, pick_channels());
            if ($urandom_range(0, 15) == 0) set_register(CFG_SPARE, GAIN_W'($urandom));
            gap_pct   = pick_pct();
            stall_pct = pick_pct();

            repeat ($urandom_range(3, 8)) begin
                kind = $urandom_range(0, 9);
                if (kind < 8) begin
                    send_buffer($urandom_range(1, 6));
                end else if (kind == 8) begin
                    // start a long buffer, then cut it short with a tiny count
                    big = $urandom_range(100, (1 << FRAMES_W) - 1);
                    repeat (chan_now * $urandom_range(1, 3))
                        send_sample(pick_sample(), FRAMES_W'(big));
                    repeat (chan_now)
                        send_sample(pick_sample(), FRAMES_W'($urandom_range(0, 1)));
                end else begin
                    // noise: a fresh frame count on every sample
                    repeat ($urandom_range(1, 8))
                        send_sample(pick_sample(), FRAMES_W'($urandom));
                end
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
